// ----- rtl/core/swlf_pkg.sv -----
// Shared types, constants and the fit micro-program for the sliding-window line fit.
`timescale 1ns / 1ps
`default_nettype none

package swlf_pkg;

   // Datapath widths fixed by the result format.
   localparam int WIDE_W = 128;
   localparam int QUO_W = 64;

   // Defaults for the top-level parameters.
   localparam int DEF_WINDOW = 64;
   localparam int DEF_COORD_BITS = 28;

   // Fraction bits of the two results.
   localparam int SLOPE_FRAC = 32;
   localparam int ICPT_FRAC = 16;

   localparam logic [QUO_W-1:0] POS_LIMIT = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

   // Value placed in the accumulator when a micro-op starts.
   typedef enum logic [2:0] {
      LD_ZERO,
      LD_KEEP,
      LD_SX,
      LD_SY,
      LD_SXX,
      LD_SXY
   } load_sel_type;

   // Multiplicand source.
   typedef enum logic [2:0] {
      OPA_OX,
      OPA_OY,
      OPA_NX,
      OPA_NY,
      OPA_SX,
      OPA_SY,
      OPA_SXX,
      OPA_SXY
   } opa_sel_type;

   // Multiplier source, consumed one bit per cycle.
   typedef enum logic [2:0] {
      OPB_ONE,
      OPB_OX,
      OPB_OY,
      OPB_NX,
      OPB_NY,
      OPB_CNT,
      OPB_SX,
      OPB_SY
   } opb_sel_type;

   // Where the accumulator goes when a micro-op ends.
   typedef enum logic [2:0] {
      ST_NONE,
      ST_SX,
      ST_SY,
      ST_SXX,
      ST_SXY,
      ST_DET,
      ST_DIVS,
      ST_DIVI
   } store_sel_type;

   typedef struct packed {
      load_sel_type  load;
      opa_sel_type   opa;
      opb_sel_type   opb;
      logic          sub;
      store_sel_type store;
   } uop_type;

   // Steps of the micro-program, in order.
   typedef enum logic [3:0] {
      ROW_OLD_SX,
      ROW_OLD_SY,
      ROW_OLD_SXX,
      ROW_OLD_SXY,
      ROW_NEW_SX,
      ROW_NEW_SY,
      ROW_NEW_SXX,
      ROW_NEW_SXY,
      ROW_DET_NSXX,
      ROW_DET_SXSX,
      ROW_NUMS_NSXY,
      ROW_NUMS_SXSY,
      ROW_NUMI_SXXSY,
      ROW_NUMI_SXSXY
   } row_type;

   // Control for the shared adder.
   typedef struct packed {
      logic sub;
      logic clear_a;
   } alu_ctl_type;

   // Each step computes acc = load +/- A * B and then passes acc to its store target, if any.
   function automatic uop_type uop_lookup(input row_type row);
      uop_type u;
      case (row)
         ROW_OLD_SX:     u = '{LD_SX,   OPA_OX,  OPB_ONE, 1'b1, ST_SX};
         ROW_OLD_SY:     u = '{LD_SY,   OPA_OY,  OPB_ONE, 1'b1, ST_SY};
         ROW_OLD_SXX:    u = '{LD_SXX,  OPA_OX,  OPB_OX,  1'b1, ST_SXX};
         ROW_OLD_SXY:    u = '{LD_SXY,  OPA_OX,  OPB_OY,  1'b1, ST_SXY};
         ROW_NEW_SX:     u = '{LD_SX,   OPA_NX,  OPB_ONE, 1'b0, ST_SX};
         ROW_NEW_SY:     u = '{LD_SY,   OPA_NY,  OPB_ONE, 1'b0, ST_SY};
         ROW_NEW_SXX:    u = '{LD_SXX,  OPA_NX,  OPB_NX,  1'b0, ST_SXX};
         ROW_NEW_SXY:    u = '{LD_SXY,  OPA_NX,  OPB_NY,  1'b0, ST_SXY};
         ROW_DET_NSXX:   u = '{LD_ZERO, OPA_SXX, OPB_CNT, 1'b0, ST_NONE};
         ROW_DET_SXSX:   u = '{LD_KEEP, OPA_SX,  OPB_SX,  1'b1, ST_DET};
         ROW_NUMS_NSXY:  u = '{LD_ZERO, OPA_SXY, OPB_CNT, 1'b0, ST_NONE};
         ROW_NUMS_SXSY:  u = '{LD_KEEP, OPA_SY,  OPB_SX,  1'b1, ST_DIVS};
         ROW_NUMI_SXXSY: u = '{LD_ZERO, OPA_SXX, OPB_SY,  1'b0, ST_NONE};
         ROW_NUMI_SXSXY: u = '{LD_KEEP, OPA_SXY, OPB_SX,  1'b1, ST_DIVI};
         default:        u = '{LD_ZERO, OPA_SX,  OPB_ONE, 1'b0, ST_NONE};
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/swlf_req_if.sv -----
// Point input channel: valid/ready handshake carrying one (x, y) item.
`timescale 1ns / 1ps
`default_nettype none

interface swlf_req_if import swlf_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swlf_rsp_if.sv -----
// Fit result channel: valid/ready handshake carrying one slope/intercept item.
`timescale 1ns / 1ps
`default_nettype none

interface swlf_rsp_if import swlf_pkg::*; #(
   parameter int WINDOW = DEF_WINDOW
);
   localparam int HELD_W = $clog2(WINDOW + 1);

   logic                    valid;
   logic                    ready;
   logic signed [QUO_W-1:0] slope;
   logic signed [QUO_W-1:0] intercept;
   logic                    fit_valid;
   logic                    saturated;
   logic [HELD_W-1:0]       points_held;

   modport source (output valid, output slope, output intercept, output fit_valid,
                   output saturated, output points_held, input ready);
   modport sink (input valid, input slope, input intercept, input fit_valid,
                 input saturated, input points_held, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swlf_addsub.sv -----
// Shared wide adder/subtractor used by every multiply and divide step.
`timescale 1ns / 1ps
`default_nettype none

module swlf_addsub import swlf_pkg::*; (
   input  logic [WIDE_W-1:0] a,
   input  logic [WIDE_W-1:0] b,
   input  alu_ctl_type       ctl,
   output logic [WIDE_W-1:0] sum,
   output logic              carry
);

   logic [WIDE_W-1:0] a_eff;
   logic [WIDE_W-1:0] b_eff;
   logic [WIDE_W:0]   full;

   // With sub set, carry out is high exactly when a >= b as unsigned values, with a read as zero under clear_a.
   assign a_eff = ctl.clear_a ? '0 : a;
   assign b_eff = ctl.sub ? ~b : b;
   assign full  = {1'b0, a_eff} + {1'b0, b_eff} + {{WIDE_W{1'b0}}, ctl.sub};
   assign sum   = full[WIDE_W-1:0];
   assign carry = full[WIDE_W];

endmodule

`default_nettype wire

// ----- rtl/core/sliding_window_line_fit.sv -----
// Top level of the sliding-window least-squares line fit.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item is an (x, y) point that enters a circular window of the
// last WINDOW points; the block keeps exact integer sums Sx, Sy, Sxx and Sxy
// and, for every item, returns one result item with the least-squares slope
// (signed Q32.32) and intercept (signed Q48.16), both truncated toward zero
// and saturated to 64 bits, plus the number of points now held. When the
// determinant n*Sxx - Sx*Sx is zero (one point, or all x equal) the result
// has fit_valid low and slope, intercept and saturated all zero. All work
// runs on one 128-bit adder under a micro-programmed sequencer: products are
// formed by shift-and-add, one multiplier bit per cycle, and each quotient by
// restoring division, one bit per cycle. A micro-op passes through a load
// state, a shift-and-add step for each significant bit of its multiplier
// magnitude and an end state, so the time per item depends on the data: the
// sum updates grow once the window is full and the oldest point is retired,
// and an item whose determinant is zero skips the numerator products and
// both divisions. The input is not ready while an item is in work. The
// result sits in an output register, so the next point is accepted while a
// finished result still waits to be taken. The point store holds no reset
// state; only slots written since reset are ever used in the sums.
module sliding_window_line_fit import swlf_pkg::*; #(
   parameter int WINDOW     = DEF_WINDOW,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   swlf_req_if.sink    req_ch,
   swlf_rsp_if.source  rsp_ch
);

   localparam int PTR_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int PT_W   = 2 * COORD_BITS;
   localparam int SUM1_W = COORD_BITS + $clog2(WINDOW);
   localparam int SUM2_W = 2 * COORD_BITS + $clog2(WINDOW);
   localparam int DET_W  = SUM2_W + CNT_W;
   localparam int DIVC_W = $clog2(QUO_W);
   localparam int HI_W   = WIDE_W - QUO_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_LOAD,
      S_STEP,
      S_END,
      S_DIV_NEG,
      S_DIV_HI,
      S_DIV_STEP,
      S_DIV_END,
      S_OUT
   } state_type;

   state_type state_ff;
   row_type   row_ff;

   // Window bookkeeping and exact running sums.
   logic [PTR_W-1:0]  wp_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SUM1_W-1:0] sx_ff;
   logic [SUM1_W-1:0] sy_ff;
   logic [SUM2_W-1:0] sxx_ff;
   logic [SUM2_W-1:0] sxy_ff;

   // Point store and the point being retired.
   logic [PT_W-1:0] mem [WINDOW];
   logic [PT_W-1:0] rd_ff;
   logic            mem_we;

   // New point.
   logic [COORD_BITS-1:0] nx_ff;
   logic [COORD_BITS-1:0] ny_ff;

   // Shared datapath registers.
   logic [WIDE_W-1:0] acc_ff;
   logic [WIDE_W-1:0] mcand_ff;
   logic [SUM1_W-1:0] mplier_ff;
   logic              msub_ff;
   logic [DET_W-1:0]  det_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [DIVC_W-1:0] div_cnt_ff;
   logic              div_slope_ff;
   logic              neg_ff;
   logic              big_ff;

   // Fit results of the item in work.
   logic [QUO_W-1:0] slope_ff;
   logic [QUO_W-1:0] icpt_ff;
   logic             fit_valid_ff;
   logic             sat_ff;

   // Output register.
   logic             rsp_valid_ff;
   logic [QUO_W-1:0] rsp_slope_ff;
   logic [QUO_W-1:0] rsp_icpt_ff;
   logic             rsp_fit_ff;
   logic             rsp_sat_ff;
   logic [CNT_W-1:0] rsp_held_ff;

   // Combinational helpers.
   uop_type               uop;
   logic [COORD_BITS-1:0] ox;
   logic [COORD_BITS-1:0] oy;
   logic                  full;
   logic [SUM2_W-1:0]     opa_val;
   logic                  opa_neg;
   logic [SUM2_W-1:0]     opa_mag;
   logic [SUM1_W-1:0]     opb_val;
   logic                  opb_neg;
   logic [SUM1_W-1:0]     opb_mag;
   logic [WIDE_W-1:0]     load_val;
   logic [WIDE_W-1:0]     u_shift;
   logic [WIDE_W-1:0]     trial;
   logic [WIDE_W-1:0]     det_ext;
   logic [WIDE_W-1:0]     alu_a;
   logic [WIDE_W-1:0]     alu_b;
   alu_ctl_type           alu_ctl;
   logic [WIDE_W-1:0]     alu_sum;
   logic                  alu_carry;
   logic [QUO_W-1:0]      quo_neg;
   logic                  pos_over;
   logic                  neg_over;
   logic                  div_sat;
   logic [QUO_W-1:0]      div_val;

   assign uop  = uop_lookup(row_ff);
   assign ox   = rd_ff[PT_W-1:COORD_BITS];
   assign oy   = rd_ff[COORD_BITS-1:0];
   assign full = (cnt_ff == CNT_W'(WINDOW));

   // Multiplicand select, taken to sign and magnitude.
   always_comb begin
      case (uop.opa)
         OPA_OX:  opa_val = {{(SUM2_W-COORD_BITS){ox[COORD_BITS-1]}}, ox};
         OPA_OY:  opa_val = {{(SUM2_W-COORD_BITS){oy[COORD_BITS-1]}}, oy};
         OPA_NX:  opa_val = {{(SUM2_W-COORD_BITS){nx_ff[COORD_BITS-1]}}, nx_ff};
         OPA_NY:  opa_val = {{(SUM2_W-COORD_BITS){ny_ff[COORD_BITS-1]}}, ny_ff};
         OPA_SX:  opa_val = {{(SUM2_W-SUM1_W){sx_ff[SUM1_W-1]}}, sx_ff};
         OPA_SY:  opa_val = {{(SUM2_W-SUM1_W){sy_ff[SUM1_W-1]}}, sy_ff};
         OPA_SXX: opa_val = sxx_ff;
         OPA_SXY: opa_val = sxy_ff;
         default: opa_val = '0;
      endcase
      opa_neg = opa_val[SUM2_W-1];
      opa_mag = opa_neg ? (~opa_val + {{(SUM2_W-1){1'b0}}, 1'b1}) : opa_val;
   end

   // Multiplier select, taken to sign and magnitude.
   always_comb begin
      case (uop.opb)
         OPB_ONE: opb_val = {{(SUM1_W-1){1'b0}}, 1'b1};
         OPB_OX:  opb_val = {{(SUM1_W-COORD_BITS){ox[COORD_BITS-1]}}, ox};
         OPB_OY:  opb_val = {{(SUM1_W-COORD_BITS){oy[COORD_BITS-1]}}, oy};
         OPB_NX:  opb_val = {{(SUM1_W-COORD_BITS){nx_ff[COORD_BITS-1]}}, nx_ff};
         OPB_NY:  opb_val = {{(SUM1_W-COORD_BITS){ny_ff[COORD_BITS-1]}}, ny_ff};
         OPB_CNT: opb_val = {{(SUM1_W-CNT_W){1'b0}}, cnt_ff};
         OPB_SX:  opb_val = sx_ff;
         OPB_SY:  opb_val = sy_ff;
         default: opb_val = '0;
      endcase
      opb_neg = opb_val[SUM1_W-1];
      opb_mag = opb_neg ? (~opb_val + {{(SUM1_W-1){1'b0}}, 1'b1}) : opb_val;
   end

   // Starting value of the accumulator.
   always_comb begin
      case (uop.load)
         LD_ZERO: load_val = '0;
         LD_KEEP: load_val = acc_ff;
         LD_SX:   load_val = {{(WIDE_W-SUM1_W){sx_ff[SUM1_W-1]}}, sx_ff};
         LD_SY:   load_val = {{(WIDE_W-SUM1_W){sy_ff[SUM1_W-1]}}, sy_ff};
         LD_SXX:  load_val = {{(WIDE_W-SUM2_W){sxx_ff[SUM2_W-1]}}, sxx_ff};
         LD_SXY:  load_val = {{(WIDE_W-SUM2_W){sxy_ff[SUM2_W-1]}}, sxy_ff};
         default: load_val = '0;
      endcase
   end

   // Divider operands. The determinant is never negative for exact sums, so
   // only the numerator needs its sign taken off.
   assign u_shift = div_slope_ff ? (acc_ff << SLOPE_FRAC) : (acc_ff << ICPT_FRAC);
   assign trial   = {acc_ff[WIDE_W-2:0], quo_ff[QUO_W-1]};
   assign det_ext = {{(WIDE_W-DET_W){1'b0}}, det_ff};

   always_comb begin
      alu_a   = acc_ff;
      alu_b   = mcand_ff;
      alu_ctl = '{sub: 1'b0, clear_a: 1'b0};
      case (state_ff)
         S_STEP: begin
            alu_ctl = '{sub: msub_ff, clear_a: 1'b0};
         end
         S_DIV_NEG: begin
            alu_b   = acc_ff;
            alu_ctl = '{sub: 1'b1, clear_a: 1'b1};
         end
         S_DIV_HI: begin
            // Quotient reaches 2^64 exactly when the upper half of the shifted
            // numerator is not below the divisor.
            alu_a   = {{QUO_W{1'b0}}, u_shift[WIDE_W-1:QUO_W]};
            alu_b   = det_ext;
            alu_ctl = '{sub: 1'b1, clear_a: 1'b0};
         end
         S_DIV_STEP: begin
            alu_a   = trial;
            alu_b   = det_ext;
            alu_ctl = '{sub: 1'b1, clear_a: 1'b0};
         end
         default: begin
            alu_a = acc_ff;
         end
      endcase
   end

   swlf_addsub u_addsub (
      .a     (alu_a),
      .b     (alu_b),
      .ctl   (alu_ctl),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   // Signed 64-bit result of a finished quotient, with clipping.
   assign quo_neg  = ~quo_ff + {{(QUO_W-1){1'b0}}, 1'b1};
   assign pos_over = big_ff | quo_ff[QUO_W-1];
   assign neg_over = big_ff | (quo_ff[QUO_W-1] & (|quo_ff[QUO_W-2:0]));
   assign div_sat  = neg_ff ? neg_over : pos_over;
   assign div_val  = neg_ff ? (neg_over ? NEG_LIMIT : quo_neg)
                            : (pos_over ? POS_LIMIT : quo_ff);

   // Point store. The read port follows the write pointer while idle, so the
   // slot about to be overwritten is on rd_ff when the item starts.
   assign mem_we = (state_ff == S_START);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= {nx_ff, ny_ff};
      end
      if (state_ff == S_IDLE) begin
         rd_ff <= mem[wp_ff];
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= ROW_OLD_SX;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         div_cnt_ff   <= '0;
         div_slope_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // While in S_OUT the output register is handled there.
         if (rsp_ch.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  nx_ff    <= req_ch.point_x;
                  ny_ff    <= req_ch.point_y;
                  state_ff <= S_START;
               end
            end
            S_START: begin
               wp_ff  <= (wp_ff == PTR_W'(WINDOW - 1)) ? '0 : wp_ff + PTR_W'(1);
               sat_ff <= 1'b0;
               if (full) begin
                  row_ff <= ROW_OLD_SX;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
                  row_ff <= ROW_NEW_SX;
               end
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               acc_ff    <= load_val;
               mcand_ff  <= {{(WIDE_W-SUM2_W){1'b0}}, opa_mag};
               mplier_ff <= opb_mag;
               msub_ff   <= uop.sub ^ opa_neg ^ opb_neg;
               state_ff  <= (opb_mag == '0) ? S_END : S_STEP;
            end
            S_STEP: begin
               if (mplier_ff[0]) begin
                  acc_ff <= alu_sum;
               end
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               if (mplier_ff[SUM1_W-1:1] == '0) begin
                  state_ff <= S_END;
               end
            end
            S_END: begin
               row_ff <= row_type'(row_ff + 4'd1);
               case (uop.store)
                  ST_SX: begin
                     sx_ff    <= acc_ff[SUM1_W-1:0];
                     state_ff <= S_LOAD;
                  end
                  ST_SY: begin
                     sy_ff    <= acc_ff[SUM1_W-1:0];
                     state_ff <= S_LOAD;
                  end
                  ST_SXX: begin
                     sxx_ff   <= acc_ff[SUM2_W-1:0];
                     state_ff <= S_LOAD;
                  end
                  ST_SXY: begin
                     sxy_ff   <= acc_ff[SUM2_W-1:0];
                     state_ff <= S_LOAD;
                  end
                  ST_DET: begin
                     det_ff <= acc_ff[DET_W-1:0];
                     if (acc_ff == '0) begin
                        // Degenerate window: no fit, all result fields zero.
                        fit_valid_ff <= 1'b0;
                        slope_ff     <= '0;
                        icpt_ff      <= '0;
                        state_ff     <= S_OUT;
                     end else begin
                        fit_valid_ff <= 1'b1;
                        state_ff     <= S_LOAD;
                     end
                  end
                  ST_DIVS: begin
                     div_slope_ff <= 1'b1;
                     state_ff     <= S_DIV_NEG;
                  end
                  ST_DIVI: begin
                     div_slope_ff <= 1'b0;
                     state_ff     <= S_DIV_NEG;
                  end
                  default: begin
                     state_ff <= S_LOAD;
                  end
               endcase
            end
            S_DIV_NEG: begin
               neg_ff <= acc_ff[WIDE_W-1];
               if (acc_ff[WIDE_W-1]) begin
                  acc_ff <= alu_sum;
               end
               state_ff <= S_DIV_HI;
            end
            S_DIV_HI: begin
               big_ff     <= alu_carry;
               acc_ff     <= {{QUO_W{1'b0}}, u_shift[WIDE_W-1:WIDE_W-HI_W]};
               quo_ff     <= u_shift[QUO_W-1:0];
               div_cnt_ff <= '0;
               state_ff   <= S_DIV_STEP;
            end
            S_DIV_STEP: begin
               acc_ff     <= alu_carry ? alu_sum : trial;
               quo_ff     <= {quo_ff[QUO_W-2:0], alu_carry};
               div_cnt_ff <= div_cnt_ff + DIVC_W'(1);
               if (div_cnt_ff == DIVC_W'(QUO_W - 1)) begin
                  state_ff <= S_DIV_END;
               end
            end
            S_DIV_END: begin
               // The row already points past the slope numerator here.
               sat_ff <= sat_ff | div_sat;
               if (div_slope_ff) begin
                  slope_ff <= div_val;
                  state_ff <= S_LOAD;
               end else begin
                  icpt_ff  <= div_val;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slope_ff <= slope_ff;
                  rsp_icpt_ff  <= icpt_ff;
                  rsp_fit_ff   <= fit_valid_ff;
                  rsp_sat_ff   <= sat_ff & fit_valid_ff;
                  rsp_held_ff  <= cnt_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.slope       = rsp_slope_ff;
   assign rsp_ch.intercept   = rsp_icpt_ff;
   assign rsp_ch.fit_valid   = rsp_fit_ff;
   assign rsp_ch.saturated   = rsp_sat_ff;
   assign rsp_ch.points_held = rsp_held_ff;

   // An accepted item keeps the input closed for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("input ready did not drop after an accepted item");

   // A window of fewer than two points can never have a fit.
   a_no_fit_below_two: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.points_held < CNT_W'(2)) |-> !rsp_ch.fit_valid)
      else $error("fit reported with fewer than two points");

   // A result without a fit carries all-zero fields.
   a_no_fit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.fit_valid |->
         (rsp_ch.slope == '0) && (rsp_ch.intercept == '0) && !rsp_ch.saturated)
      else $error("result without a fit has nonzero fields");

   // The number of points held is reported as at least one and at most WINDOW.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.points_held <= CNT_W'(WINDOW)) &&
                       (rsp_ch.points_held != '0))
      else $error("points held out of range");

endmodule

`default_nettype wire

// ----- sim/swlf_fit_checker.sv -----
// Predictor and result comparison for the sliding-window line fit testbench.
`timescale 1ns / 1ps

module swlf_fit_checker import swlf_pkg::*; #(
   parameter int WINDOW     = DEF_WINDOW,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic clock,
   input  logic reset,
   swlf_req_if  req_mon,
   swlf_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   fits_pending
);

   localparam int HELD_W = $clog2(WINDOW + 1);

   typedef struct {
      logic [QUO_W-1:0]  slope;
      logic [QUO_W-1:0]  intercept;
      logic              fit_valid;
      logic              saturated;
      logic [HELD_W-1:0] points_held;
   } line_fit_type;

   line_fit_type expected_fits[$];
   line_fit_type oldest_fit;

   // Shadow copy of the window and its exact running sums.
   longint win_x [WINDOW];
   longint win_y [WINDOW];
   int     next_slot;
   int     held;
   longint sum_x, sum_y, sum_xx, sum_xy;
   int     errors;

   // (num << frac) / den truncated toward zero, clipped to 64 signed bits.
   function automatic logic [QUO_W-1:0] scaled_quotient(
      input  logic signed [WIDE_W-1:0] num,
      input  logic signed [WIDE_W-1:0] den,
      input  int                       frac,
      output logic                     clipped
   );
      logic [WIDE_W-1:0] mag_num;
      logic [WIDE_W-1:0] mag_den;
      logic [WIDE_W-1:0] quo;
      logic              negative;
      clipped  = 1'b0;
      negative = num[WIDE_W-1] ^ den[WIDE_W-1];
      mag_num  = num[WIDE_W-1] ? -num : num;
      mag_den  = den[WIDE_W-1] ? -den : den;
      quo      = (mag_num << frac) / mag_den;
      if (!negative) begin
         if (quo > {{(WIDE_W-QUO_W){1'b0}}, POS_LIMIT}) begin
            clipped = 1'b1;
            return POS_LIMIT;
         end
         return quo[QUO_W-1:0];
      end
      if (quo > {{(WIDE_W-QUO_W){1'b0}}, NEG_LIMIT}) begin
         clipped = 1'b1;
         return NEG_LIMIT;
      end
      return -quo[QUO_W-1:0];
   endfunction

   // Retires the oldest point when the window is full, adds the new one and
   // returns the fit over the points now held.
   function automatic line_fit_type insert_and_fit(input longint x, input longint y);
      logic signed [WIDE_W-1:0] n_w, sx_w, sy_w, sxx_w, sxy_w;
      logic signed [WIDE_W-1:0] det, num_slope, num_icpt;
      logic                     clip_slope, clip_icpt;
      line_fit_type             fit;
      if (held >= WINDOW) begin
         sum_x  -= win_x[next_slot];
         sum_y  -= win_y[next_slot];
         sum_xx -= win_x[next_slot] * win_x[next_slot];
         sum_xy -= win_x[next_slot] * win_y[next_slot];
      end else begin
         held++;
      end
      sum_x  += x;
      sum_y  += y;
      sum_xx += x * x;
      sum_xy += x * y;
      win_x[next_slot] = x;
      win_y[next_slot] = y;
      next_slot = (next_slot + 1) % WINDOW;

      n_w   = WIDE_W'(held);
      sx_w  = WIDE_W'(sum_x);
      sy_w  = WIDE_W'(sum_y);
      sxx_w = WIDE_W'(sum_xx);
      sxy_w = WIDE_W'(sum_xy);
      det   = n_w * sxx_w - sx_w * sx_w;

      fit.slope       = '0;
      fit.intercept   = '0;
      fit.fit_valid   = 1'b0;
      fit.saturated   = 1'b0;
      fit.points_held = HELD_W'(held);
      if (det != 0) begin
         num_slope     = n_w * sxy_w - sx_w * sy_w;
         num_icpt      = sxx_w * sy_w - sx_w * sxy_w;
         fit.fit_valid = 1'b1;
         fit.slope     = scaled_quotient(num_slope, det, SLOPE_FRAC, clip_slope);
         fit.intercept = scaled_quotient(num_icpt, det, ICPT_FRAC, clip_icpt);
         fit.saturated = clip_slope | clip_icpt;
      end
      return fit;
   endfunction

   task automatic check_field(input string field, input logic [QUO_W-1:0] want,
                              input logic [QUO_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_fits.delete();
         next_slot = 0;
         held      = 0;
         sum_x     = 0;
         sum_y     = 0;
         sum_xx    = 0;
         sum_xy    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_fits.size() == 0) begin
               $error("result item arrived with no point waiting for it");
               errors++;
            end else begin
               oldest_fit = expected_fits.pop_front();
               check_field("slope", oldest_fit.slope, rsp_mon.slope);
               check_field("intercept", oldest_fit.intercept, rsp_mon.intercept);
               check_field("fit_valid", QUO_W'(oldest_fit.fit_valid),
                           QUO_W'(rsp_mon.fit_valid));
               check_field("saturated", QUO_W'(oldest_fit.saturated),
                           QUO_W'(rsp_mon.saturated));
               check_field("points_held", QUO_W'(oldest_fit.points_held),
                           QUO_W'(rsp_mon.points_held));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_fits.push_back(insert_and_fit(longint'(req_mon.point_x),
                                                   longint'(req_mon.point_y)));
         end
      end
      mismatch_count <= errors;
      fits_pending   <= expected_fits.size();
   end

endmodule

// ----- sim/testbench.sv -----
// Top of the sliding-window line fit testbench: clock, reset, point stimulus and verdict.
`timescale 1ns / 1ps

// The block takes one (x, y) point per item and answers each one with a
// single fit item. This top only produces stimulus and reports the outcome;
// prediction and comparison live in the checker instance beside the block,
// which watches both channels and hands back its failure count.
//
// Stimulus runs in two parts. A short directed part hits the coordinate
// extremes, the zero-determinant cases (a lone point, then a second point
// with the same x) and a pair of points steep and far enough from the origin
// to clip the intercept. The random part is built from segments, each with
// its own point pattern, so that the window fills, wraps and retires old
// points under many kinds of data: full-range noise, noisy straight lines
// with small x steps, long runs with one fixed x (which drive the
// determinant back to zero once every other x has left the window), tiny
// values, and coordinate corners.
module testbench;

   import swlf_pkg::*;

   localparam int WINDOW       = DEF_WINDOW;
   localparam int COORD_BITS   = DEF_COORD_BITS;
   localparam int RANDOM_ITEMS = 1440;
   // Random stalls on the result side add little to the time an item takes in the block.
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 600;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef enum int {
      PAT_SPREAD,
      PAT_TREND,
      PAT_FIXED_X,
      PAT_TINY,
      PAT_CORNER
   } point_pattern_type;

   logic clock = 1'b0;
   logic reset;
   logic idling_on;
   int   mismatch_count;
   int   fits_pending;

   swlf_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   swlf_rsp_if #(.WINDOW(WINDOW))         rsp_ch ();

   sliding_window_line_fit #(
      .WINDOW    (WINDOW),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   swlf_fit_checker #(
      .WINDOW    (WINDOW),
      .COORD_BITS(COORD_BITS)
   ) fit_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .mismatch_count(mismatch_count),
      .fits_pending  (fits_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The result side takes items at random, except while idling is off.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !idling_on || ($urandom_range(99) >= 16);
      end
   end

   // Watchdog: the run is stuck if neither channel moves an item for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("testbench NOT OK");
      $finish;
   end

   // Offers one point and returns at the edge where the block takes it. A
   // random gap goes first while idling is on; valid is only lowered in a gap,
   // so back-to-back points keep it high without a glitch.
   task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y);
      while (idling_on && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.point_x <= x;
      req_ch.point_y <= y;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic signed [COORD_BITS-1:0] corner_coord();
      case ($urandom_range(4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return '1;
         default: return COORD_BITS'(1);
      endcase
   endfunction

   initial begin
      point_pattern_type                pattern;
      int                               segment_left;
      int                               item;
      int                               trend_x, trend_step, trend_gain, trend_base;
      logic signed [COORD_BITS-1:0]     fixed_x;
      logic signed [COORD_BITS-1:0]     px, py;

      reset          <= 1'b1;
      idling_on      <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.point_x <= '0;
      req_ch.point_y <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A lone point, then a second with the same x: both have no fit.
      send_point(COORD_MAX, COORD_MAX);
      send_point(COORD_MAX, COORD_MIN);
      // Opposite x extreme gives a fit over the full coordinate range.
      send_point(COORD_MIN, COORD_MAX);
      send_point('0, '0);
      send_point(COORD_BITS'(1), COORD_BITS'(-1));
      send_point(COORD_BITS'(-1), COORD_BITS'(1));
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, '0);
      send_point('0, COORD_MAX);
      send_point(28'sh5555555, 28'shAAAAAAA);
      send_point(28'shAAAAAAA, 28'sh5555555);
      // A steep pair far out on x pushes the intercept past its range; the
      // window still holds the earlier points, so fill it with this pair
      // pattern for a while to make the clipped case dominate.
      repeat (6) begin
         send_point(COORD_MAX, COORD_MAX);
         send_point(COORD_MAX - COORD_BITS'(1), COORD_MIN);
      end

      segment_left = 0;
      pattern      = PAT_SPREAD;
      trend_x      = 0;
      trend_step   = 1;
      trend_gain   = 0;
      trend_base   = 0;
      fixed_x      = '0;
      for (item = 0; item < RANDOM_ITEMS; item++) begin
         // A long stretch in the middle runs with both sides always willing.
         idling_on <= !(item >= 600 && item < 800);
         if (segment_left == 0) begin
            pattern = point_pattern_type'($urandom_range(4));
            segment_left = (pattern == PAT_FIXED_X) ? $urandom_range(90, 70)
                                                    : $urandom_range(60, 10);
            trend_x    = $urandom_range(2000000) - 1000000;
            trend_step = $urandom_range(1000, 1);
            trend_gain = $urandom_range(8) - 4;
            trend_base = $urandom_range(2000000) - 1000000;
            fixed_x    = COORD_BITS'($urandom);
         end
         segment_left--;
         case (pattern)
            PAT_TREND: begin
               trend_x += trend_step;
               px = COORD_BITS'(trend_x);
               py = COORD_BITS'(trend_gain * trend_x + trend_base
                                + $urandom_range(128) - 64);
            end
            PAT_FIXED_X: begin
               px = fixed_x;
               py = COORD_BITS'($urandom);
            end
            PAT_TINY: begin
               px = COORD_BITS'($urandom_range(16) - 8);
               py = COORD_BITS'($urandom_range(16) - 8);
            end
            PAT_CORNER: begin
               px = corner_coord();
               py = corner_coord();
            end
            default: begin
               px = COORD_BITS'($urandom);
               py = COORD_BITS'($urandom);
            end
         endcase
         send_point(px, py);
      end
      req_ch.valid <= 1'b0;

      // The registered pending count shows the last point from the next edge on.
      @(posedge clock);
      while (fits_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
